// ===== sv/lcmu_pkg.sv =====
`timescale 1ns / 1ps

package lcmu_pkg;

    localparam int OPERAND_WIDTH_DEFAULT = 32;
    localparam int IN_WIDTH              = 32;
    localparam int LCM_WIDTH             = 64;

    typedef logic [IN_WIDTH-1:0]  operand_t;
    typedef logic [LCM_WIDTH-1:0] lcm_t;

    typedef logic [3:0] op_t;
    typedef logic [2:0] jump_t;
    typedef logic [3:0] pc_t;

    localparam op_t OP_NOP   = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_STRIP = 4'd2;
    localparam op_t OP_GCD   = 4'd3;
    localparam op_t OP_SCALE = 4'd4;
    localparam op_t OP_DIV   = 4'd5;
    localparam op_t OP_MINIT = 4'd6;
    localparam op_t OP_MUL   = 4'd7;
    localparam op_t OP_EMIT  = 4'd8;

    localparam jump_t J_NONE      = 3'd0;
    localparam jump_t J_ALWAYS    = 3'd1;
    localparam jump_t J_NO_REQ    = 3'd2;
    localparam jump_t J_ZERO      = 3'd3;
    localparam jump_t J_BOTH_EVEN = 3'd4;
    localparam jump_t J_NOT_EQUAL = 3'd5;
    localparam jump_t J_CNT_MORE  = 3'd6;
    localparam jump_t J_OUT_BUSY  = 3'd7;

    localparam pc_t S_WAIT  = 4'd0;
    localparam pc_t S_CHKZ  = 4'd1;
    localparam pc_t S_STRIP = 4'd2;
    localparam pc_t S_GCD   = 4'd3;
    localparam pc_t S_SCALE = 4'd4;
    localparam pc_t S_DIV   = 4'd5;
    localparam pc_t S_MINIT = 4'd6;
    localparam pc_t S_MUL   = 4'd7;
    localparam pc_t S_EMIT  = 4'd8;
    localparam pc_t S_BACK  = 4'd9;

    typedef struct packed {
        op_t   op;
        jump_t jump;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic req;
        logic zero;
        logic both_even;
        logic not_equal;
        logic cnt_more;
        logic out_busy;
    } lcmu_status_t;

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        begin
            case (pc)
                S_WAIT:  w = '{op: OP_LOAD,  jump: J_NO_REQ,    target: S_WAIT};
                S_CHKZ:  w = '{op: OP_NOP,   jump: J_ZERO,      target: S_EMIT};
                S_STRIP: w = '{op: OP_STRIP, jump: J_BOTH_EVEN, target: S_STRIP};
                S_GCD:   w = '{op: OP_GCD,   jump: J_NOT_EQUAL, target: S_GCD};
                S_SCALE: w = '{op: OP_SCALE, jump: J_NONE,      target: S_WAIT};
                S_DIV:   w = '{op: OP_DIV,   jump: J_CNT_MORE,  target: S_DIV};
                S_MINIT: w = '{op: OP_MINIT, jump: J_NONE,      target: S_WAIT};
                S_MUL:   w = '{op: OP_MUL,   jump: J_CNT_MORE,  target: S_MUL};
                S_EMIT:  w = '{op: OP_EMIT,  jump: J_OUT_BUSY,  target: S_EMIT};
                S_BACK:  w = '{op: OP_NOP,   jump: J_ALWAYS,    target: S_WAIT};
                default: w = '{op: OP_NOP,   jump: J_ALWAYS,    target: S_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== sv/lcmu_seq.sv =====
`timescale 1ns / 1ps

module lcmu_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcmu_pkg::lcmu_status_t status,
    output lcmu_pkg::op_t        op
);
    import lcmu_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t word;
    logic   take;

    assign word = ucode(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        case (word.jump)
            J_NONE:      take = 1'b0;
            J_ALWAYS:    take = 1'b1;
            J_NO_REQ:    take = !status.req;
            J_ZERO:      take = status.zero;
            J_BOTH_EVEN: take = status.both_even;
            J_NOT_EQUAL: take = status.not_equal;
            J_CNT_MORE:  take = status.cnt_more;
            J_OUT_BUSY:  take = status.out_busy;
            default:     take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/least_common_multiple_unit.sv =====
`timescale 1ns / 1ps

// Least common multiple of two unsigned operands, result at double width.
// Input channel: in_valid / in_ready carry value_a and value_b; only the low
// OPERAND_WIDTH bits of each are used. Output channel: out_valid / out_ready
// carry lcm_value and zero_operand. A zero operand gives lcm_value 0 with
// zero_operand set.
// One request is worked at a time by a microcoded sequencer: a binary
// gcd, a restoring divide a/gcd and a shift-add multiply by b, one step per
// cycle. A zero operand skips them and goes straight to the output step.
// After each result the sequencer passes through a return step before
// in_ready rises again. The result sits in an output register, so a new
// request is accepted and worked while the receiver stalls; the sequencer
// holds at its final step until that register is free. Reset clears the
// sequencer and out_valid, so in_ready is high from reset on.
module least_common_multiple_unit #(
    parameter int OPERAND_WIDTH = lcmu_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcmu_pkg::operand_t value_a,
    input  lcmu_pkg::operand_t value_b,
    output logic               out_valid,
    input  logic               out_ready,
    output lcmu_pkg::lcm_t     lcm_value,
    output logic               zero_operand
);
    import lcmu_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    op_t          op;
    lcmu_status_t status;
    logic         req;

    // x: gcd operand, then remainder, then product high half
    // y: gcd operand, then gcd
    // a: operand a, then quotient, then product low half
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          zero_reg, zero_next;

    logic          out_valid_reg, out_valid_next;
    lcm_t          lcm_value_reg, lcm_value_next;
    logic          zero_operand_reg, zero_operand_next;

    logic [W:0]    rem_sh;
    logic [W:0]    rem_diff;
    logic          rem_ge;
    logic [W:0]    msum;
    logic [2*W-1:0] prod;

    lcmu_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    assign in_ready     = (op == OP_LOAD);
    assign req          = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign lcm_value    = lcm_value_reg;
    assign zero_operand = zero_operand_reg;

    assign status.req       = req;
    assign status.zero      = zero_reg;
    assign status.both_even = !x_reg[0] && !y_reg[0];
    assign status.not_equal = (x_reg != y_reg);
    assign status.cnt_more  = (cnt_reg != CW'(W - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign rem_sh   = {x_reg, a_reg[W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, y_reg});
    assign rem_diff = rem_sh - {1'b0, y_reg};
    assign msum     = {1'b0, x_reg} + (a_reg[0] ? {1'b0, b_reg} : {(W+1){1'b0}});
    assign prod     = {x_reg, a_reg};

    always_comb
    begin
        x_next            = x_reg;
        y_next            = y_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        k_next            = k_reg;
        cnt_next          = cnt_reg;
        zero_next         = zero_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        lcm_value_next    = lcm_value_reg;
        zero_operand_next = zero_operand_reg;
        case (op)
            OP_LOAD:
            begin
                if (req)
                begin
                    x_next    = value_a[W-1:0];
                    y_next    = value_b[W-1:0];
                    a_next    = value_a[W-1:0];
                    b_next    = value_b[W-1:0];
                    k_next    = '0;
                    zero_next = (value_a[W-1:0] == '0) || (value_b[W-1:0] == '0);
                end
            end
            OP_STRIP:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
            end
            OP_GCD:
            begin
                if (x_reg != y_reg)
                begin
                    if (!x_reg[0])
                        x_next = x_reg >> 1;
                    else if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_reg > y_reg)
                        x_next = x_reg - y_reg;
                    else
                        y_next = y_reg - x_reg;
                end
            end
            OP_SCALE:
            begin
                y_next   = x_reg << k_reg;
                x_next   = '0;
                cnt_next = '0;
            end
            OP_DIV:
            begin
                x_next   = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
                a_next   = {a_reg[W-2:0], rem_ge};
                cnt_next = cnt_reg + CW'(1);
            end
            OP_MINIT:
            begin
                x_next   = '0;
                cnt_next = '0;
            end
            OP_MUL:
            begin
                x_next   = msum[W:1];
                a_next   = {msum[0], a_reg[W-1:1]};
                cnt_next = cnt_reg + CW'(1);
            end
            OP_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    lcm_value_next    = zero_reg ? '0 : lcm_t'(prod);
                    zero_operand_next = zero_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        a_reg            <= a_next;
        b_reg            <= b_next;
        k_reg            <= k_next;
        cnt_reg          <= cnt_next;
        zero_reg         <= zero_next;
        lcm_value_reg    <= lcm_value_next;
        zero_operand_reg <= zero_operand_next;
    end

endmodule
